// ===== design/dcs_pkg.sv =====
// Shared types and codes for the dispense cycle sequencer.
package dcs_pkg;

  // Fixed field widths of the channel beats.
  localparam int unsigned ORDER_TAG_W = 64;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned HOLD_W      = 16;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_COMMAND       = 2'd0;
  localparam logic [1:0] OP_TICK          = 2'd1;
  localparam logic [1:0] OP_CLEAR_SESSION = 2'd2;

  // Phase codes of the sequencer.
  localparam logic [1:0] PH_IDLE     = 2'd0;
  localparam logic [1:0] PH_DISPENSE = 2'd1;
  localparam logic [1:0] PH_FINISHED = 2'd2;

  // Display message codes.
  localparam logic [2:0] MSG_NONE        = 3'd0;
  localparam logic [2:0] MSG_DISPENSING  = 3'd1;
  localparam logic [2:0] MSG_DISP_ERROR  = 3'd2;
  localparam logic [2:0] MSG_FINISHED    = 3'd3;
  localparam logic [2:0] MSG_READY       = 3'd4;

  // Power-on value of the finish hold register.
  localparam logic [HOLD_W-1:0] FINISH_HOLD_RESET = 16'd2000;

  // Payload of one input beat.
  typedef struct packed {
    logic [1:0]             operation;
    logic [ORDER_TAG_W-1:0] order_tag;
    logic [TIME_W-1:0]      allowance_ms;
    logic [TIME_W-1:0]      now_ms;
    logic                   wake_ready;
    logic                   standby_active;
    logic                   start_ok;
    logic                   busy_req;
    logic                   done_pending;
  } cmd_t;

  // Payload of one result beat.
  typedef struct packed {
    logic                   accepted;
    logic                   start_request;
    logic                   standby_request;
    logic                   went_idle;
    logic [2:0]             message_code;
    logic                   cycle_active;
    logic [ORDER_TAG_W-1:0] active_order;
  } res_t;

  // Sequencer control state apart from the order tags.
  typedef struct packed {
    logic [1:0]        phase;
    logic [TIME_W-1:0] wd_deadline;
    logic [TIME_W-1:0] fin_deadline;
    logic              wd_tripped;
  } ctl_t;

endpackage

// ===== design/dcs_cmd_if.sv =====
// Valid/ready channel that carries input beats.
interface dcs_cmd_if;
  logic          valid;
  logic          ready;
  dcs_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/dcs_res_if.sv =====
// Valid/ready channel that carries result beats.
interface dcs_res_if;
  logic          valid;
  logic          ready;
  dcs_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/dcs_step.sv =====
// Next-state and result logic for one input beat of the sequencer.
module dcs_step #(
  parameter int unsigned TagBits = 64
) (
  input  dcs_pkg::cmd_t                   item_i,
  input  dcs_pkg::ctl_t                   ctl_i,
  input  logic [TagBits-1:0]              last_i,
  input  logic [TagBits-1:0]              cur_i,
  input  logic [dcs_pkg::HOLD_W-1:0]      hold_i,
  output dcs_pkg::ctl_t                   ctl_o,
  output logic [TagBits-1:0]              last_o,
  output logic [TagBits-1:0]              cur_o,
  output dcs_pkg::res_t                   res_o
);
  import dcs_pkg::*;

  logic [TagBits-1:0] tag;
  logic [TIME_W-1:0]  wd_left;
  logic [TIME_W-1:0]  hold_diff;
  logic               wd_expired;
  logic               hold_over;
  logic               tripped_now;

  assign tag        = item_i.order_tag[TagBits-1:0];
  assign wd_left    = ctl_i.wd_deadline - item_i.now_ms;
  assign hold_diff  = item_i.now_ms - ctl_i.fin_deadline;
  // Wrap-safe compares: the difference read as a signed value.
  assign wd_expired = (wd_left == '0) || wd_left[TIME_W-1];
  assign hold_over  = !hold_diff[TIME_W-1];

  always_comb begin
    ctl_o       = ctl_i;
    last_o      = last_i;
    cur_o       = cur_i;
    tripped_now = 1'b0;
    res_o       = '0;
    res_o.message_code = MSG_NONE;

    case (item_i.operation)
      OP_COMMAND: begin
        // A start is only tried for a fresh order while idle and awake.
        if ((tag != '0) && (ctl_i.phase == PH_IDLE) && (tag != last_i) &&
            item_i.wake_ready) begin
          res_o.standby_request = !item_i.standby_active;
          res_o.start_request   = 1'b1;
          if (item_i.start_ok) begin
            last_o             = tag;
            cur_o              = tag;
            ctl_o.phase        = PH_DISPENSE;
            ctl_o.wd_deadline  = item_i.now_ms + item_i.allowance_ms;
            ctl_o.wd_tripped   = 1'b0;
            ctl_o.fin_deadline = '0;
            res_o.message_code = MSG_DISPENSING;
            res_o.accepted     = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (ctl_i.phase != PH_IDLE) begin
          // Watchdog trips once while the dispenser is still busy.
          if (!ctl_i.wd_tripped && wd_expired && item_i.busy_req) begin
            tripped_now        = 1'b1;
            ctl_o.wd_tripped   = 1'b1;
            res_o.message_code = MSG_DISP_ERROR;
          end
          if (ctl_i.phase == PH_DISPENSE) begin
            if (item_i.done_pending) begin
              ctl_o.phase        = PH_FINISHED;
              ctl_o.fin_deadline = item_i.now_ms + TIME_W'(hold_i);
              res_o.message_code = (ctl_i.wd_tripped || tripped_now) ?
                                   MSG_DISP_ERROR : MSG_FINISHED;
            end
          end else if (hold_over) begin
            // Hold time is over: back to idle and drop the order.
            ctl_o.phase           = PH_IDLE;
            ctl_o.wd_tripped      = 1'b0;
            cur_o                 = '0;
            res_o.message_code    = MSG_READY;
            res_o.standby_request = 1'b1;
            res_o.went_idle       = 1'b1;
          end
        end
      end
      OP_CLEAR_SESSION: begin
        last_o = '0;
      end
      default: begin
        // Unused operation: the state is reported unchanged.
      end
    endcase

    res_o.cycle_active = (ctl_o.phase != PH_IDLE);
    res_o.active_order = ORDER_TAG_W'(cur_o);
  end

endmodule

// ===== design/dispense_cycle_sequencer_core.sv =====
// Top level of the dispense cycle sequencer: beat registers and sequencer state.
//
// Usage: input beats arrive on cmd_i (valid/ready) and carry either a command,
// a time tick with the dispenser flags, or a session clear. Every accepted
// beat yields exactly one result beat on res_o, in order.
// Flow: a beat is captured in the input register at the edge it is taken,
// worked out by the step logic and placed in the result register once that
// register is free or emptying; its result is then valid on res_o.
// Throughput: one beat per cycle unless res_o is held off; the single pass
// of compare and add logic between the input and result registers sets it.
// Stall: while res_o is held off, the result register keeps its beat and
// one more beat waits in the input register; cmd_i.ready then drops until
// the receiver takes the pending result.
// Configuration: cfg_we_i writes cfg_wdata_i into the finish hold time. The
// user must do so only while no beat is in flight; the block does not check.
// Reset: rst_ni clears both registers' valid flags, returns the phase to
// idle, clears the deadlines, the watchdog flag and both order tags, and sets
// the finish hold time to 2000 ms. The block is ready in the first cycle.
module dispense_cycle_sequencer_core #(
  parameter int unsigned ORDER_TAG_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dcs_pkg::HOLD_W-1:0] cfg_wdata_i,
  dcs_cmd_if.sink                    cmd_i,
  dcs_res_if.source                  res_o
);
  import dcs_pkg::*;

  logic                      in_valid_q;
  cmd_t                      in_item_q;
  logic                      out_valid_q;
  res_t                      out_res_q;
  ctl_t                      ctl_q, ctl_d;
  logic [ORDER_TAG_BITS-1:0] last_q, last_d;
  logic [ORDER_TAG_BITS-1:0] cur_q, cur_d;
  logic [HOLD_W-1:0]         hold_q;
  res_t                      res_d;
  logic                      advance;

  // A held beat moves on whenever the result register is free or emptying.
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_res_q;

  dcs_step #(
    .TagBits (ORDER_TAG_BITS)
  ) u_step (
    .item_i (in_item_q),
    .ctl_i  (ctl_q),
    .last_i (last_q),
    .cur_i  (cur_q),
    .hold_i (hold_q),
    .ctl_o  (ctl_d),
    .last_o (last_d),
    .cur_o  (cur_d),
    .res_o  (res_d)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      in_item_q <= cmd_i.payload;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  // Sequencer state, updated as each beat passes to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      last_q <= '0;
      cur_q  <= '0;
    end else if (advance) begin
      ctl_q  <= ctl_d;
      last_q <= last_d;
      cur_q  <= cur_d;
    end
  end

  // Finish hold time register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= FINISH_HOLD_RESET;
    end else if (cfg_we_i) begin
      hold_q <= cfg_wdata_i;
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the dispense cycle sequencer core.
module testbench;
  import dcs_pkg::*;

  localparam int unsigned CLK_HALF      = 4;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned RANDOM_BEATS  = 1150;
  localparam int unsigned HOLD_SETTINGS = 6;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned MAX_GAP       = 6;

  // Operation code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Dispenser status flags, ordered {wake, standby, start_ok, busy, done}.
  localparam logic [4:0] FL_NONE     = 5'b00000;
  localparam logic [4:0] FL_WAKE     = 5'b10000;
  localparam logic [4:0] FL_STANDBY  = 5'b01000;
  localparam logic [4:0] FL_START_OK = 5'b00100;
  localparam logic [4:0] FL_BUSY     = 5'b00010;
  localparam logic [4:0] FL_DONE     = 5'b00001;
  localparam logic [4:0] FL_GO       = FL_WAKE | FL_STANDBY | FL_START_OK;
  localparam logic [4:0] FL_ALL      = 5'b11111;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [HOLD_W-1:0]   cfg_wdata_i;

  dcs_cmd_if cmd_ch ();
  dcs_res_if res_ch ();

  dispense_cycle_sequencer_core #(
    .ORDER_TAG_BITS(ORDER_TAG_W)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_ch),
    .res_o      (res_ch)
  );

  // Predicted sequencer state and the hold register as last written.
  logic [1:0]             seq_phase;
  logic [TIME_W-1:0]      seq_wd_deadline;
  logic [TIME_W-1:0]      seq_fin_deadline;
  logic                   seq_wd_tripped;
  logic [ORDER_TAG_W-1:0] seq_last_tag;
  logic [ORDER_TAG_W-1:0] seq_cur_tag;
  logic [HOLD_W-1:0]      seq_hold_ms;

  res_t              expected_results[$];
  int unsigned       fault_count = 0;
  int unsigned       cycle_count = 0;
  bit                tx_gaps     = 1'b1;
  bit                rx_gaps     = 1'b1;
  logic [TIME_W-1:0] clock_ms;

  always #(CLK_HALF) clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Works out the result of one beat and advances the predicted state.
  function automatic res_t sequencer_predict(input cmd_t c);
    res_t              r;
    logic [TIME_W-1:0] left;
    logic [TIME_W-1:0] since;
    r = '0;
    case (c.operation)
      OP_COMMAND: begin
        if (c.order_tag != '0 && seq_phase == PH_IDLE && c.order_tag != seq_last_tag &&
            c.wake_ready) begin
          r.standby_request = !c.standby_active;
          r.start_request   = 1'b1;
          if (c.start_ok) begin
            seq_last_tag     = c.order_tag;
            seq_cur_tag      = c.order_tag;
            seq_phase        = PH_DISPENSE;
            seq_wd_deadline  = c.now_ms + c.allowance_ms;
            seq_wd_tripped   = 1'b0;
            seq_fin_deadline = '0;
            r.message_code   = MSG_DISPENSING;
            r.accepted       = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (seq_phase != PH_IDLE) begin
          // The watchdog fires once the deadline is reached, modulo wrap.
          left = seq_wd_deadline - c.now_ms;
          if (!seq_wd_tripped && (left == '0 || left[TIME_W-1]) && c.busy_req) begin
            seq_wd_tripped = 1'b1;
            r.message_code = MSG_DISP_ERROR;
          end
          if (seq_phase == PH_DISPENSE) begin
            if (c.done_pending) begin
              seq_phase        = PH_FINISHED;
              seq_fin_deadline = c.now_ms + TIME_W'(seq_hold_ms);
              r.message_code   = seq_wd_tripped ? MSG_DISP_ERROR : MSG_FINISHED;
            end
          end else begin
            since = c.now_ms - seq_fin_deadline;
            if (!since[TIME_W-1]) begin
              seq_phase         = PH_IDLE;
              seq_cur_tag       = '0;
              seq_wd_tripped    = 1'b0;
              r.message_code    = MSG_READY;
              r.standby_request = 1'b1;
              r.went_idle       = 1'b1;
            end
          end
        end
      end
      OP_CLEAR_SESSION: begin
        seq_last_tag = '0;
      end
      default: begin
      end
    endcase
    r.cycle_active = (seq_phase != PH_IDLE);
    r.active_order = seq_cur_tag;
    return r;
  endfunction

  function automatic cmd_t make_beat(input logic [1:0] op, input logic [ORDER_TAG_W-1:0] tag,
                                     input logic [TIME_W-1:0] dur, input logic [TIME_W-1:0] now,
                                     input logic [4:0] flags);
    cmd_t b;
    b.operation      = op;
    b.order_tag      = tag;
    b.allowance_ms   = dur;
    b.now_ms         = now;
    b.wake_ready     = flags[4];
    b.standby_active = flags[3];
    b.start_ok       = flags[2];
    b.busy_req       = flags[1];
    b.done_pending   = flags[0];
    return b;
  endfunction

  // Offers one beat after a random gap and records its expected result once taken.
  task automatic send_beat(input cmd_t beat);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid   <= 1'b1;
    cmd_ch.payload <= beat;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    expected_results.push_back(sequencer_predict(beat));
  endtask

  // Stops offering beats and waits until every result has been taken.
  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes the finish hold time with nothing in flight.
  task automatic write_hold(input logic [HOLD_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    seq_hold_ms = value;
  endtask

  task automatic note_fault(input string what, input logic [71:0] want, input logic [71:0] got);
    fault_count++;
    if (fault_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
  endtask

  // Compares one taken result beat with the oldest expectation.
  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      note_fault("unexpected result beat", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.accepted !== want.accepted)
        note_fault("accepted", 72'(want.accepted), 72'(got.accepted));
      if (got.start_request !== want.start_request)
        note_fault("start_request", 72'(want.start_request), 72'(got.start_request));
      if (got.standby_request !== want.standby_request)
        note_fault("standby_request", 72'(want.standby_request), 72'(got.standby_request));
      if (got.went_idle !== want.went_idle)
        note_fault("went_idle", 72'(want.went_idle), 72'(got.went_idle));
      if (got.message_code !== want.message_code)
        note_fault("message_code", 72'(want.message_code), 72'(got.message_code));
      if (got.cycle_active !== want.cycle_active)
        note_fault("cycle_active", 72'(want.cycle_active), 72'(got.cycle_active));
      if (got.active_order !== want.active_order)
        note_fault("active_order", 72'(want.active_order), 72'(got.active_order));
    end
  endtask

  // Result receiver: random stalls before each beat, then checks it.
  initial begin : result_sink
    int unsigned stall;
    res_ch.ready = 1'b0;
    forever begin
      stall = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (res_ch.valid !== 1'b1);
      check_result(res_ch.payload);
    end
  end

  // Draws the next beat from the predicted phase, mostly well-formed cycles.
  function automatic cmd_t next_random_beat();
    cmd_t        b;
    int unsigned pick;
    int unsigned step_max;
    b = make_beat(2'($urandom_range(0, 3)), {$urandom, $urandom}, $urandom, $urandom,
                  5'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      return b;
    end
    step_max = seq_hold_ms / 3 + 20;
    if (seq_phase == PH_IDLE) begin
      if (pick < 20) begin
        b.operation = OP_CLEAR_SESSION;
      end else if (pick < 28) begin
        b.operation = OP_TICK;
        b.now_ms    = clock_ms;
      end else begin
        b.operation = OP_COMMAND;
        b.now_ms    = clock_ms;
        if (pick < 33)
          b.order_tag = seq_last_tag;
        else if (pick < 35)
          b.order_tag = '0;
        b.wake_ready = ($urandom_range(0, 9) != 0);
        b.start_ok   = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 9) != 0)
          b.allowance_ms = $urandom_range(0, step_max * 3);
      end
    end else if (pick < 16) begin
      // A command while busy must be turned away.
      b.operation = OP_COMMAND;
    end else begin
      b.operation = OP_TICK;
      if ($urandom_range(0, 49) == 0)
        clock_ms = $urandom;
      else
        clock_ms = clock_ms + $urandom_range(0, step_max);
      b.now_ms       = clock_ms;
      b.busy_req     = ($urandom_range(0, 9) < 7);
      b.done_pending = ($urandom_range(0, 3) == 0);
    end
    return b;
  endfunction

  // Special cases at the reset hold time, one field extreme after another.
  task automatic test_directed_cases();
    logic [ORDER_TAG_W-1:0] top_tag;
    top_tag = '1;
    // Idle tick, empty tag, dispenser asleep, start refused.
    send_beat(make_beat(OP_TICK, '0, '0, '0, FL_BUSY | FL_DONE));
    send_beat(make_beat(OP_COMMAND, '0, 32'd10, '0, FL_GO));
    send_beat(make_beat(OP_COMMAND, 64'h5, 32'd10, '0, FL_STANDBY | FL_START_OK));
    send_beat(make_beat(OP_COMMAND, 64'h5, 32'd10, '0, FL_WAKE));
    // Accepted with a deadline that wraps past zero, then a command while busy.
    send_beat(make_beat(OP_COMMAND, top_tag, 32'h20, 32'hFFFF_FFF0, FL_GO));
    send_beat(make_beat(OP_COMMAND, 64'h7, 32'd10, '0, FL_GO));
    // Watchdog: early, at the deadline without busy, then tripping.
    send_beat(make_beat(OP_TICK, '0, '0, 32'hFFFF_FFF8, FL_BUSY));
    send_beat(make_beat(OP_TICK, '0, '0, 32'h10, FL_NONE));
    send_beat(make_beat(OP_TICK, '0, '0, 32'h10, FL_BUSY));
    send_beat(make_beat(OP_TICK, '0, '0, 32'h11, FL_BUSY | FL_DONE));
    // Hold time one short, then exactly reached.
    send_beat(make_beat(OP_TICK, '0, '0, 32'h11 + 32'd1999, FL_NONE));
    send_beat(make_beat(OP_TICK, '0, '0, 32'h11 + 32'd2000, FL_NONE));
    // Repeated tag is refused until the session is cleared.
    send_beat(make_beat(OP_COMMAND, top_tag, 32'd5, '0, FL_GO));
    send_beat(make_beat(OP_CLEAR_SESSION, top_tag, '1, '1, FL_ALL));
    send_beat(make_beat(OP_COMMAND, top_tag, 32'hFFFF_FFFF, '0, FL_WAKE | FL_START_OK));
    send_beat(make_beat(OP_TICK, '0, '0, 32'd5, FL_DONE));
    // Watchdog trips in the finished phase; hold compare at the signed boundary.
    send_beat(make_beat(OP_TICK, '0, '0, 32'hFFFF_FFFF, FL_BUSY));
    send_beat(make_beat(OP_TICK, '0, '0, 32'd2005 + 32'h8000_0000, FL_NONE));
    send_beat(make_beat(OP_TICK, '0, '0, 32'd2005 + 32'h7FFF_FFFF, FL_NONE));
    send_beat(make_beat(OP_UNUSED, '1, '1, '1, FL_ALL));
    // Smallest tag with no allowance: trips and finishes on one tick.
    send_beat(make_beat(OP_COMMAND, 64'h1, '0, 32'h100, FL_GO));
    send_beat(make_beat(OP_TICK, '0, '0, 32'h100, FL_BUSY | FL_DONE));
    send_beat(make_beat(OP_TICK, '0, '0, 32'h100 + 32'd2000, FL_BUSY));
    drain_results();
  endtask

  // Shortest and longest hold times, with the clock wrapping past zero after the finish deadline.
  task automatic test_hold_extremes();
    write_hold('0);
    send_beat(make_beat(OP_COMMAND, 64'hA5A5_A5A5_A5A5_A5A5, 32'h8000_0000, 32'd100, FL_GO));
    send_beat(make_beat(OP_TICK, '0, '0, 32'd101, FL_BUSY));
    send_beat(make_beat(OP_TICK, '0, '0, 32'd100, FL_BUSY | FL_DONE));
    send_beat(make_beat(OP_TICK, '0, '0, 32'd100, FL_NONE));
    write_hold('1);
    send_beat(make_beat(OP_COMMAND, 64'h5A5A_5A5A_5A5A_5A5A, 32'd1000, 32'hFFFF_0000, FL_GO));
    send_beat(make_beat(OP_TICK, '0, '0, 32'hFFFF_0000, FL_DONE));
    send_beat(make_beat(OP_TICK, '0, '0, 32'hFFFF_FFFE, FL_NONE));
    send_beat(make_beat(OP_TICK, '0, '0, '0, FL_NONE));
    drain_results();
  endtask

  // Random traffic over several hold settings and flow-control mixes.
  task automatic test_random_traffic();
    logic [HOLD_W-1:0] hold_plan[HOLD_SETTINGS];
    hold_plan = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 200)), 16'($urandom),
                  16'd1, FINISH_HOLD_RESET};
    foreach (hold_plan[k]) begin
      write_hold(hold_plan[k]);
      clock_ms = $urandom;
      for (int unsigned i = 0; i < RANDOM_BEATS / HOLD_SETTINGS + 1; i++) begin
        if (i % 40 == 0) begin
          tx_gaps = ($urandom_range(0, 3) != 0);
          rx_gaps = ($urandom_range(0, 3) != 0);
        end
        send_beat(next_random_beat());
      end
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin : stimulus
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = FINISH_HOLD_RESET;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    seq_phase        = PH_IDLE;
    seq_wd_deadline  = '0;
    seq_fin_deadline = '0;
    seq_wd_tripped   = 1'b0;
    seq_last_tag     = '0;
    seq_cur_tag      = '0;
    seq_hold_ms      = FINISH_HOLD_RESET;
    clock_ms         = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_hold_extremes();
    test_random_traffic();
    drain_results();

    if (fault_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
